### rtl/weighted_triangle_angle_histogram_macros.svh
// Assertion macros for the angle histogram checker.
// Used only by the checker file; depends on nothing.
`ifndef WEIGHTED_TRIANGLE_ANGLE_HISTOGRAM_MACROS_SVH
`define WEIGHTED_TRIANGLE_ANGLE_HISTOGRAM_MACROS_SVH

// An implication that must hold in the same cycle.
`define WTAH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// An implication that must hold in the following cycle.
`define WTAH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wtah_pkg.sv
// Shared types, constants and the cosine threshold function of the angle histogram.
// Depends on nothing; used by every module of the block.
package wtah_pkg;

	localparam int NUM_BINS_DEF = 64;
	localparam int ACC_W        = 48;
	localparam int LEN_W        = 32;
	localparam int RB_W         = 6;
	localparam int IN_DATA_W    = 136;
	localparam int OUT_DATA_W   = 56;
	localparam logic [63:0] PI_Q40  = 64'h3243F6A8885;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	localparam logic [63:0] SERIES_DIV [1:12] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;
	localparam logic ST_DONE  = 1'b0;
	localparam logic ST_DEGEN = 1'b1;

	typedef enum logic [2:0] {
		T_CLEAR,
		T_IDLE,
		T_SEARCH,
		T_READ,
		T_WRITE
	} top_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ,
		S_DIFF,
		S_LO,
		S_HI,
		S_CMP
	} srch_state_t;

	// Taylor series of the cosine in signed Q2.30 from an angle in unsigned Q24.40.
	function automatic logic signed [31:0] cos_q30(input logic [63:0] x40);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x    = x40 >> 10;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = 64'sd1 <<< 30;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x2) >> 30) / SERIES_DIV[n];
			if (n % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		return 32'(sum);
	endfunction

endpackage

### rtl/wtah_hist_mem.sv
// Histogram storage: one synchronous memory, one write and one registered read port.
// Depends on wtah_pkg for the accumulator width.
module wtah_hist_mem #(
	parameter int Depth = wtah_pkg::NUM_BINS_DEF,
	parameter int AddrW = $clog2(Depth)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AddrW-1:0]            waddr,
	input  logic [wtah_pkg::ACC_W-1:0]  wdata,
	input  logic [AddrW-1:0]            raddr,
	output logic [wtah_pkg::ACC_W-1:0]  rdata_q
);

	logic [wtah_pkg::ACC_W-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

endmodule

### rtl/wtah_bin_search.sv
// Finds the angle bin of a triangle by a binary search over the cosine thresholds.
// Depends on wtah_pkg for the threshold function, constants and state type.
module wtah_bin_search #(
	parameter int NumBins = wtah_pkg::NUM_BINS_DEF,
	parameter int IdxW    = $clog2(NumBins)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wtah_pkg::LEN_W-1:0]  side_ab,
	input  logic [wtah_pkg::LEN_W-1:0]  side_ac,
	input  logic [wtah_pkg::LEN_W-1:0]  side_bc,
	output logic                        done,
	output logic [IdxW-1:0]             bin
);

	logic signed [31:0] thr_tab [NumBins];

	for (genvar k = 0; k < NumBins; k++) begin : g_thr
		localparam bit FOLD = (2 * k > NumBins);
		localparam int KF = FOLD ? NumBins - k : k;
		localparam logic [63:0] X40 = 64'(KF) * wtah_pkg::PI_Q40 / 64'(NumBins);
		localparam logic signed [31:0] COS = wtah_pkg::cos_q30(X40);
		assign thr_tab[k] = (k == 0) ? 32'sd0 : (FOLD ? -COS : COS);
	end

	wtah_pkg::srch_state_t state_q, state_d;

	logic [31:0]  a_q, b_q, d_q;
	logic [63:0]  aa_q, bb_q, dd_q, ab_q;
	logic [95:0]  lhs_q;
	logic         neg_q;
	logic [IdxW-1:0] cnt_q, mask_q;
	logic [31:0]  tm2_q;
	logic         tneg_q, cand_ok_q;
	logic [63:0]  plo_q, phi_q;

	logic [IdxW-1:0] cand;
	logic         cand_ok;
	logic signed [31:0] t_sel;
	logic [64:0]  p_sum, q_sq, mag;
	logic         neg_c;
	logic [95:0]  rhs;
	logic         le;

	assign cand    = cnt_q | mask_q;
	assign cand_ok = {1'b0, cand} < (IdxW + 1)'(NumBins);
	assign t_sel   = cand_ok ? thr_tab[cand] : 32'sd0;
	assign p_sum   = {1'b0, aa_q} + {1'b0, bb_q};
	assign q_sq    = {1'b0, dd_q};
	assign neg_c   = p_sum < q_sq;
	assign mag     = neg_c ? q_sq - p_sum : p_sum - q_sq;
	assign rhs     = {phi_q, 32'd0} + {32'd0, plo_q};

	always_comb begin
		if (!neg_q && !tneg_q)
			le = lhs_q <= rhs;
		else if (neg_q && !tneg_q)
			le = 1'b1;
		else if (!neg_q && tneg_q)
			le = 1'b0;
		else
			le = lhs_q >= rhs;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wtah_pkg::S_IDLE: if (start) state_d = wtah_pkg::S_SQ;
			wtah_pkg::S_SQ:   state_d = wtah_pkg::S_DIFF;
			wtah_pkg::S_DIFF: state_d = wtah_pkg::S_LO;
			wtah_pkg::S_LO:   state_d = wtah_pkg::S_HI;
			wtah_pkg::S_HI:   state_d = wtah_pkg::S_CMP;
			wtah_pkg::S_CMP:  state_d = mask_q[0] ? wtah_pkg::S_IDLE : wtah_pkg::S_LO;
			default:          state_d = wtah_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		done = 1'b0;
		unique case (state_q)
			wtah_pkg::S_CMP: done = mask_q[0];
			default:         done = 1'b0;
		endcase
	end

	assign bin = (le && cand_ok_q) ? cand : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtah_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wtah_pkg::S_IDLE: begin
				a_q <= side_ab;
				b_q <= side_ac;
				d_q <= side_bc;
			end
			wtah_pkg::S_SQ: begin
				aa_q <= 64'(a_q) * 64'(a_q);
				bb_q <= 64'(b_q) * 64'(b_q);
				dd_q <= 64'(d_q) * 64'(d_q);
				ab_q <= 64'(a_q) * 64'(b_q);
			end
			wtah_pkg::S_DIFF: begin
				lhs_q  <= {mag[65-1:0], 30'd0} & 96'h7FFFFFFFFFFFFFFFFFFFFFFF;
				neg_q  <= neg_c;
				cnt_q  <= '0;
				mask_q <= IdxW'(1) << (IdxW - 1);
			end
			wtah_pkg::S_LO: begin
				tneg_q    <= t_sel[31];
				tm2_q     <= (t_sel[31] ? 32'(-t_sel) : 32'(t_sel)) << 1;
				cand_ok_q <= cand_ok;
				plo_q     <= 64'(ab_q[31:0])
					* 64'((t_sel[31] ? 32'(-t_sel) : 32'(t_sel)) << 1);
			end
			wtah_pkg::S_HI: begin
				phi_q <= 64'(ab_q[63:32]) * 64'(tm2_q);
			end
			wtah_pkg::S_CMP: begin
				cnt_q  <= bin;
				mask_q <= mask_q >> 1;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/weighted_triangle_angle_histogram.sv
// A read or a dropped add runs through T_READ and T_WRITE to its result word; an add
// runs T_SEARCH first, with one S_LO, S_HI, S_CMP search step per bin index bit.
// One word is in work at a time: a new word is taken only after T_WRITE hands on the last.
// After reset every histogram bin is cleared with s_tready low.
// Depends on wtah_pkg, wtah_bin_search and wtah_hist_mem.
module weighted_triangle_angle_histogram #(
	parameter int NumBins = wtah_pkg::NUM_BINS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// side_ab, side_ac, side_bc, weight, read_bin, zero padding
	input  logic [wtah_pkg::IN_DATA_W-1:0]    s_tdata,
	// req_type
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// bin_index, bin_value, zero padding
	output logic [wtah_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status
	output logic                              m_tuser
);

	localparam int IdxW = $clog2(NumBins);

	wtah_pkg::top_state_t state_q, state_d;

	logic [IdxW-1:0]  clr_cnt_q;
	logic             is_read_q, degen_q, in_range_q;
	logic [31:0]      weight_q;
	logic [5:0]       rb_q;
	logic [IdxW-1:0]  addr_q;
	logic             m_valid_q, m_status_q;
	logic [5:0]       m_index_q;
	logic [47:0]      m_value_q;

	logic             accept, srch_start, srch_done;
	logic [IdxW-1:0]  srch_bin;
	logic             mem_we;
	logic [IdxW-1:0]  mem_waddr;
	logic [47:0]      mem_wdata, rd_data;
	logic [48:0]      sum;
	logic [47:0]      sat;
	logic             slot_free;
	logic             in_degen;

	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;
	assign in_degen  = (s_tdata[31:0] == '0) || (s_tdata[63:32] == '0);
	assign sum       = {1'b0, rd_data} + 49'(weight_q);
	assign sat       = sum[48] ? wtah_pkg::ACC_MAX : sum[47:0];

	wtah_bin_search #(.NumBins(NumBins), .IdxW(IdxW)) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (srch_start),
		.side_ab (s_tdata[31:0]),
		.side_ac (s_tdata[63:32]),
		.side_bc (s_tdata[95:64]),
		.done    (srch_done),
		.bin     (srch_bin)
	);

	wtah_hist_mem #(.Depth(NumBins), .AddrW(IdxW)) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (addr_q),
		.rdata_q (rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wtah_pkg::T_CLEAR:
				if (clr_cnt_q == IdxW'(NumBins - 1)) state_d = wtah_pkg::T_IDLE;
			wtah_pkg::T_IDLE:
				if (accept) begin
					if (s_tuser == wtah_pkg::REQ_READ || in_degen)
						state_d = wtah_pkg::T_READ;
					else
						state_d = wtah_pkg::T_SEARCH;
				end
			wtah_pkg::T_SEARCH:
				if (srch_done) state_d = wtah_pkg::T_READ;
			wtah_pkg::T_READ:
				state_d = wtah_pkg::T_WRITE;
			wtah_pkg::T_WRITE:
				if (slot_free) state_d = wtah_pkg::T_IDLE;
			default:
				state_d = wtah_pkg::T_CLEAR;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		srch_start = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = sat;
		unique case (state_q)
			wtah_pkg::T_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			wtah_pkg::T_IDLE: begin
				s_tready   = 1'b1;
				srch_start = s_tvalid && s_tuser == wtah_pkg::REQ_ADD && !in_degen;
			end
			wtah_pkg::T_WRITE:
				mem_we = slot_free && !is_read_q && !degen_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wtah_pkg::T_CLEAR;
			clr_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wtah_pkg::T_CLEAR)
				clr_cnt_q <= clr_cnt_q + IdxW'(1);
			if (state_q == wtah_pkg::T_WRITE && slot_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_q  <= s_tuser == wtah_pkg::REQ_READ;
			degen_q    <= s_tuser == wtah_pkg::REQ_ADD && in_degen;
			weight_q   <= s_tdata[127:96];
			rb_q       <= s_tdata[133:128];
			in_range_q <= 13'(s_tdata[133:128]) < 13'(NumBins);
			addr_q     <= IdxW'(s_tdata[133:128]);
		end
		if (state_q == wtah_pkg::T_SEARCH && srch_done)
			addr_q <= srch_bin;
		if (state_q == wtah_pkg::T_WRITE && slot_free) begin
			if (is_read_q) begin
				m_status_q <= wtah_pkg::ST_DONE;
				m_index_q  <= rb_q;
				m_value_q  <= in_range_q ? rd_data : '0;
			end else if (degen_q) begin
				m_status_q <= wtah_pkg::ST_DEGEN;
				m_index_q  <= '0;
				m_value_q  <= '0;
			end else begin
				m_status_q <= wtah_pkg::ST_DONE;
				m_index_q  <= 6'(addr_q);
				m_value_q  <= sat;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {2'b00, m_value_q, m_index_q};

endmodule

### rtl/wtah_chk.sv
// Port-level checker of the angle histogram, bound to the top level.
// Depends on wtah_pkg and the assertion macro header.
`include "weighted_triangle_angle_histogram_macros.svh"

module wtah_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [wtah_pkg::IN_DATA_W-1:0]    s_tdata,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [wtah_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic                              m_tuser
);

	`WTAH_ASSERT_NOW(a_degen_zero, clk, arst_n, m_tvalid && m_tuser == wtah_pkg::ST_DEGEN, m_tdata == '0, "Dropped triangle word carries data.")
	`WTAH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled output word changed.")
	`WTAH_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "Input accepted while a word is in work.")
	`WTAH_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[55:54] == 2'b00, "Output padding bits set.")

endmodule

bind weighted_triangle_angle_histogram wtah_chk u_wtah_chk (.*);

### tb/sv/weighted_triangle_angle_histogram_tb.sv
// Self-checking testbench of the weighted triangle angle histogram: stream words in, compare
// every result word against a bin predictor kept in the bench, under several flow control regimes.
// Depends on wtah_pkg and weighted_triangle_angle_histogram.
`timescale 1ns / 1ps

module weighted_triangle_angle_histogram_tb;

	localparam int BINS = wtah_pkg::NUM_BINS_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic        req;
		logic [31:0] ab;
		logic [31:0] ac;
		logic [31:0] bc;
		logic [31:0] wt;
		logic [5:0]  rbin;
	} tri_req_t;

	typedef struct packed {
		logic        status;
		logic [5:0]  bin;
		logic [47:0] value;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [wtah_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [wtah_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	tri_req_t pending_words[$];
	bin_result_t expected_results[$];
	logic [47:0] hist_model [BINS];
	logic signed [63:0] cos_thr [BINS];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_count = 0;
	int quiet_cycles = 0;
	bit failed = 1'b0;

	weighted_triangle_angle_histogram dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [63:0] series_cos(int k);
		logic [63:0] x, x2, term;
		logic signed [63:0] sum;
		bit neg;
		neg = 1'b0;
		if (2 * k > BINS) begin
			k = BINS - k;
			neg = 1'b1;
		end
		x = ((64'(k) * wtah_pkg::PI_Q40) / 64'(BINS)) >> 10;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = 64'sd1 <<< 30;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		return neg ? -sum : sum;
	endfunction

	function automatic int angle_bin(logic [31:0] a, logic [31:0] b, logic [31:0] d);
		logic [127:0] p, q, mag, lhs, rhs, tm;
		logic [63:0] ab;
		bit neg, le;
		int count;
		count = 0;
		p = 128'(a) * 128'(a) + 128'(b) * 128'(b);
		q = 128'(d) * 128'(d);
		neg = p < q;
		mag = neg ? q - p : p - q;
		lhs = mag << 30;
		ab = 64'(a) * 64'(b);
		for (int k = 1; k < BINS; k++) begin
			tm = cos_thr[k] < 0 ? 128'(-cos_thr[k]) : 128'(cos_thr[k]);
			rhs = 128'(ab) * (2 * tm);
			if (!neg && cos_thr[k] >= 0)
				le = lhs <= rhs;
			else if (neg && cos_thr[k] >= 0)
				le = 1'b1;
			else if (!neg)
				le = 1'b0;
			else
				le = lhs >= rhs;
			if (le)
				count++;
		end
		return count;
	endfunction

	function automatic bin_result_t predict_histogram(tri_req_t w);
		bin_result_t r;
		logic [63:0] sum;
		int b;
		if (w.req == wtah_pkg::REQ_READ) begin
			r.status = wtah_pkg::ST_DONE;
			r.bin = w.rbin;
			r.value = (int'(w.rbin) < BINS) ? hist_model[w.rbin] : '0;
		end else if (w.ab == 0 || w.ac == 0) begin
			r = '{wtah_pkg::ST_DEGEN, 6'd0, 48'd0};
		end else begin
			b = angle_bin(w.ab, w.ac, w.bc);
			sum = 64'(hist_model[b]) + 64'(w.wt);
			if (sum > 64'(wtah_pkg::ACC_MAX))
				sum = 64'(wtah_pkg::ACC_MAX);
			hist_model[b] = sum[47:0];
			r = '{wtah_pkg::ST_DONE, 6'(b), sum[47:0]};
		end
		return r;
	endfunction

	function automatic void push_word(logic req, logic [31:0] a, logic [31:0] b,
		logic [31:0] d, logic [31:0] w, logic [5:0] rb);
		pending_words.push_back('{req, a, b, d, w, rb});
	endfunction

	function automatic void push_random_word();
		int sel;
		logic [32:0] lo, hi, d;
		logic [31:0] a, b;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			a = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0100_0000);
			b = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0100_0000);
			if (a == 0) a = 1;
			if (b == 0) b = 1;
			lo = a > b ? a - b : b - a;
			hi = 33'(a) + 33'(b);
			d = lo + 33'($urandom) % (hi - lo + 1);
			if (d > 33'hFFFF_FFFF) d = 33'hFFFF_FFFF;
			push_word(wtah_pkg::REQ_ADD, a, b, d[31:0],
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0003_0000),
				6'($urandom));
		end else if (sel < 72)
			push_word(wtah_pkg::REQ_READ, $urandom, $urandom, $urandom, $urandom,
				6'($urandom));
		else if (sel < 80)
			push_word(wtah_pkg::REQ_ADD, $urandom_range(0, 1) ? 32'd0 : $urandom,
				$urandom_range(0, 1) ? 32'd0 : $urandom, $urandom, $urandom, 6'($urandom));
		else
			push_word(1'($urandom), $urandom, $urandom, $urandom, $urandom, 6'($urandom));
	endfunction

	// Driver: the front of the pending queue is the word on offer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_histogram(pending_words.pop_front()));
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_words[0].req;
					s_tdata <= {2'b00, pending_words[0].rbin, pending_words[0].wt,
						pending_words[0].bc, pending_words[0].ac, pending_words[0].ab};
				end else begin
					s_tvalid <= 1'b0;
				end
			end else if (!s_tvalid && pending_words.size() != 0
				&& $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_words[0].req;
				s_tdata <= {2'b00, pending_words[0].rbin, pending_words[0].wt,
					pending_words[0].bc, pending_words[0].ac, pending_words[0].ab};
			end
		end
	end

	// Monitor and receiver side, with the long hold-off counted here.
	always @(posedge clk) begin
		bin_result_t want;
		bin_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[5:0], m_tdata[53:6]};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected word status=%0d bin=%0d value=%h",
						$time, got.status, got.bin, got.value);
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status)
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
					if (got.bin !== want.bin)
						$display("%0t: bin_index expected %0d actual %0d", $time,
							want.bin, got.bin);
					if (got.value !== want.value)
						$display("%0t: bin_value expected %h actual %h", $time,
							want.value, got.value);
					if (got !== want)
						failed = 1'b1;
				end
			end
			if (hold_request && hold_count == 0)
				hold_count = 400;
			if (hold_count > 0) begin
				hold_count = hold_count - 1;
				if (hold_count == 0)
					hold_request = 1'b0;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("weighted_triangle_angle_histogram_tb: FAIL");
			$finish;
		end
	end

	task automatic drain();
		while (pending_words.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			push_random_word();
		drain();
	endtask

	initial begin
		for (int b = 0; b < BINS; b++)
			hist_model[b] = '0;
		cos_thr[0] = 0;
		for (int k = 1; k < BINS; k++)
			cos_thr[k] = series_cos(k);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_word(wtah_pkg::REQ_READ, '0, '0, '0, '0, 6'd0);
		push_word(wtah_pkg::REQ_READ, '1, '1, '1, '1, 6'd63);
		push_word(wtah_pkg::REQ_ADD, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			6'd0);
		push_word(wtah_pkg::REQ_ADD, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0001_0000,
			6'd5);
		push_word(wtah_pkg::REQ_ADD, '1, '1, '1, '1, 6'd0);
		push_word(wtah_pkg::REQ_ADD, '1, '1, 32'd0, '1, 6'd0);
		push_word(wtah_pkg::REQ_ADD, 32'd1, 32'd1, '1, 32'd7, 6'd0);
		push_word(wtah_pkg::REQ_ADD, 32'd1, 32'd1, 32'd0, 32'd1, 6'd0);
		push_word(wtah_pkg::REQ_ADD, '1, 32'd1, 32'd0, 32'd3, 6'd0);
		push_word(wtah_pkg::REQ_ADD, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
			32'h0001_0000, 6'd0);
		push_word(wtah_pkg::REQ_ADD, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
			32'h0000_8000, 6'd0);
		push_word(wtah_pkg::REQ_ADD, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'd9,
			6'd0);
		push_word(wtah_pkg::REQ_ADD, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'd9,
			6'd0);
		push_word(wtah_pkg::REQ_READ, '0, '0, '0, '0, 6'd21);
		push_word(wtah_pkg::REQ_READ, '0, '0, '0, '0, 6'd32);
		push_word(wtah_pkg::REQ_READ, '0, '0, '0, '0, 6'd0);
		drain();

		run_phase(0, 0, 200);
		run_phase(83, 0, 150);
		run_phase(0, 83, 150);
		run_phase(27, 27, 200);
		hold_request = 1'b1;
		run_phase(0, 0, 100);
		run_phase(0, 0, 100);

		repeat (100) @(posedge clk);
		if (failed)
			$display("weighted_triangle_angle_histogram_tb: FAIL");
		else
			$display("weighted_triangle_angle_histogram_tb: PASS");
		$finish;
	end

endmodule
